[hw/rtl/gho_pkg.sv]
package gho_pkg;

    // CORDIC arctangent table, binary angle with 2^32 per turn
    localparam int ATAN_LEN = 40;
    localparam int CNT_W    = $clog2(ATAN_LEN);
    typedef logic [29:0] atan_t;
    localparam atan_t ATAN_TAB [ATAN_LEN] = '{
        30'd536870912, 30'd316933405, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335086,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41721,
        30'd20860, 30'd10430, 30'd5215, 30'd2607, 30'd1303,
        30'd651, 30'd325, 30'd162, 30'd81, 30'd40,
        30'd20, 30'd10, 30'd5, 30'd2, 30'd1,
        30'd0, 30'd0, 30'd0, 30'd0, 30'd0,
        30'd0, 30'd0, 30'd0, 30'd0, 30'd0
    };

    localparam int CX_W = 36;
    localparam int CZ_W = 34;
    localparam logic signed [CX_W-1:0] CORDIC_X0 = 36'sd2608131496;

    // degree-to-angle conversion: (m << shift + D/2) / D
    localparam int DIV_N_W = 62;
    localparam logic [28:0] DIV_D    = 29'd450000000;
    localparam logic [27:0] DIV_HALF = 28'd225000000;

    localparam int MUL_W = 32;
    localparam logic [MUL_W-1:0] MM_PER_TURN = 32'd156367866;

    localparam int STEP_W    = 35;
    localparam int ODO_OUT_W = 47;

    localparam logic [1:0] OP_FIX         = 2'd0;
    localparam logic [1:0] OP_CLR_DAILY   = 2'd1;
    localparam logic [1:0] OP_CLR_SERVICE = 2'd2;

    localparam logic CFG_SPEED_THRESHOLD = 1'b0;
    localparam logic CFG_MAX_STEP        = 1'b1;

    typedef struct packed {
        logic start;
        logic vectoring;
    } cordic_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_CONV,
        ST_ROT,
        ST_MLAUNCH,
        ST_MUL,
        ST_RLAUNCH,
        ST_ROOT,
        ST_VEC,
        ST_SCALE,
        ST_ACCUM,
        ST_FINISH
    } gho_state_t;

endpackage

[hw/rtl/gho_stream_if.sv]
interface gho_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [30:0] latitude;
    logic signed [31:0] longitude;
    logic               location_valid;
    logic               speed_valid;
    logic [17:0]        speed;

    modport source (
        output valid, opcode, latitude, longitude, location_valid, speed_valid, speed,
        input  ready
    );
    modport sink (
        input  valid, opcode, latitude, longitude, location_valid, speed_valid, speed,
        output ready
    );
endinterface

interface gho_out_if;
    logic        valid;
    logic        ready;
    logic [46:0] daily_mm;
    logic [46:0] total_mm;
    logic [46:0] service_mm;
    logic [34:0] step_mm;
    logic        step_counted;
    logic        position_known;

    modport source (
        output valid, daily_mm, total_mm, service_mm, step_mm, step_counted,
        output position_known,
        input  ready
    );
    modport sink (
        input  valid, daily_mm, total_mm, service_mm, step_mm, step_counted,
        input  position_known,
        output ready
    );
endinterface

[hw/rtl/gho_div.sv]
module gho_div
    import gho_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    output logic [31:0]        quotient,
    output logic               done
);
    localparam int DCNT_W = $clog2(DIV_N_W);

    logic [DIV_N_W-1:0] n_reg;
    logic [28:0]        r_reg;
    logic [31:0]        q_reg;
    logic [DCNT_W-1:0]  cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [29:0] trial;
    logic        ge;

    // one quotient bit per cycle against the fixed divisor
    always_comb
    begin
        trial = {r_reg, n_reg[DIV_N_W-1]};
        ge    = trial >= {1'b0, DIV_D};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIV_N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= dividend;
            r_reg <= '0;
            q_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[DIV_N_W-2:0], 1'b0};
            r_reg <= ge ? 29'(trial - {1'b0, DIV_D}) : trial[28:0];
            q_reg <= {q_reg[30:0], ge};
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;
endmodule

[hw/rtl/gho_cordic.sv]
module gho_cordic
    import gho_pkg::*;
#(
    parameter int ITERATIONS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cordic_cmd_t            cmd,
    input  logic signed [CX_W-1:0] x0,
    input  logic signed [CX_W-1:0] y0,
    input  logic signed [CZ_W-1:0] z0,
    output logic signed [CX_W-1:0] x,
    output logic signed [CX_W-1:0] y,
    output logic signed [CZ_W-1:0] z,
    output logic                   done
);
    localparam int N = (ITERATIONS > ATAN_LEN) ? ATAN_LEN : ITERATIONS;

    logic signed [CX_W-1:0] x_reg, y_reg;
    logic signed [CZ_W-1:0] z_reg;
    logic                   vec_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic signed [CX_W-1:0] dx, dy;
    logic signed [CZ_W-1:0] at;
    logic                   pos;

    always_comb
    begin
        dx  = y_reg >>> cnt_reg;
        dy  = x_reg >>> cnt_reg;
        at  = $signed({{(CZ_W-30){1'b0}}, ATAN_TAB[cnt_reg]});
        // rotation steers z to zero, vectoring steers y to zero
        pos = vec_reg ? (y_reg <= 0) : (z_reg >= 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(N - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg   <= x0;
            y_reg   <= y0;
            z_reg   <= z0;
            vec_reg <= cmd.vectoring;
        end
        else if (busy_reg)
        begin
            x_reg <= pos ? x_reg - dx : x_reg + dx;
            y_reg <= pos ? y_reg + dy : y_reg - dy;
            z_reg <= pos ? z_reg - at : z_reg + at;
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;
    assign done = done_reg;
endmodule

[hw/rtl/gho_mul.sv]
module gho_mul
    import gho_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MUL_W-1:0]     a,
    input  logic [MUL_W-1:0]     b,
    output logic [2*MUL_W-1:0]   p,
    output logic                 done
);
    localparam int MCNT_W = $clog2(MUL_W);

    logic [MUL_W-1:0]  a_reg, hi_reg, lo_reg;
    logic [MCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [MUL_W:0]    sum;

    // add on the low multiplier bit, then shift the pair right
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MCNT_W'(MUL_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[MUL_W:1];
            lo_reg <= {sum[0], lo_reg[MUL_W-1:1]};
        end
    end

    assign p    = {hi_reg, lo_reg};
    assign done = done_reg;
endmodule

[hw/rtl/gho_sqrt.sv]
module gho_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [32:0] v,
    output logic [31:0] root,
    output logic        done
);
    logic [63:0] x_reg, r_reg, b_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = r_reg + b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && b_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // v * 2^32, saturated
            x_reg <= v[32] ? '1 : {v[31:0], 32'd0};
            r_reg <= '0;
            b_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_reg <= x_reg - trial;
                r_reg <= (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            b_reg <= b_reg >> 2;
        end
    end

    assign root = r_reg[31:0];
    assign done = done_reg;
endmodule

[hw/rtl/gps_haversine_odometer_top.sv]
// GPS haversine odometer.
// item: one beat per parsed fix or command (fix, clear daily, clear service).
// result: one beat per item with the three odometers in mm, the step distance,
// whether it was counted, and whether a position is stored.
// cfg_we/cfg_index/cfg_data write the speed threshold (index 0) and the jump
// limit (index 1); write only while no item is in flight.
// A fix that follows a stored position runs through four angle conversions
// (bit-serial divide, each with its launch) each followed by a CORDIC
// rotation, four serial multiplies, two serial roots, a CORDIC vectoring pass
// and a final serial multiply before the result load. Other items go
// straight to the result load. One item is worked on at a time.
// The result sits in an output register; a new item is taken while it waits,
// and the block holds in its last step until the receiver takes that beat.
// Reset clears the odometers, the stored position and the registers to 300
// and 500000.
module gps_haversine_odometer_top
    import gho_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 32,
    parameter int ODOMETER_WIDTH    = 48
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [19:0]  cfg_data,
    gho_in_if.sink       item,
    gho_out_if.source    result
);
    localparam int OW = ODOMETER_WIDTH;
    localparam int SW = ((OW > STEP_W) ? OW : STEP_W) + 1;
    localparam int CW = (OW > ODO_OUT_W) ? OW : ODO_OUT_W;

    gho_state_t state_reg, state_next;

    logic [17:0]        thr_reg;
    logic [19:0]        maxstep_reg;
    logic signed [31:0] prev_lat_reg, prev_lon_reg;
    logic               have_prev_reg;
    logic [OW-1:0]      daily_reg, total_reg, service_reg;

    logic signed [31:0] lat_reg, lon_reg;
    logic               spd_valid_reg;
    logic [17:0]        speed_reg;
    logic [1:0]         idx_reg;
    logic               neg_reg, flip_reg;
    logic signed [32:0] sl_reg, sn_reg, c1_reg, c2_reg;
    logic [31:0]        m1_reg, m2_reg, m3_reg, ra_reg;
    logic               s2_reg;
    logic [32:0]        hav_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               counted_reg;

    logic                 out_valid_reg;
    logic [ODO_OUT_W-1:0] out_daily_reg, out_total_reg, out_service_reg;
    logic [STEP_W-1:0]    out_step_reg;
    logic                 out_counted_reg, out_known_reg;

    logic                   div_start, div_done;
    logic [DIV_N_W-1:0]     dividend;
    logic [31:0]            div_q;
    cordic_cmd_t            cx_cmd;
    logic signed [CX_W-1:0] cx_x0, cx_y0, cx_x, cx_y;
    logic signed [CZ_W-1:0] cx_z0, cx_z;
    logic                   cx_done;
    logic                   mul_start, mul_done;
    logic [MUL_W-1:0]       mul_a, mul_b;
    logic [2*MUL_W-1:0]     mul_p;
    logic                   sqrt_start, sqrt_done;
    logic [32:0]            sqrt_v;
    logic [31:0]            sqrt_r;
    logic                   load_out;
    logic                   accept;

    logic signed [32:0]     vsrc, vabs;
    logic [31:0]            ang, ang2;
    logic                   flip;
    logic signed [CX_W-1:0] xs, ys;
    logic [63:0]            prod_rnd, scale_rnd;
    logic [31:0]            mq;
    logic signed [33:0]     hsum;
    logic [32:0]            hav_c;
    logic [30:0]            zc;
    logic                   counted;

    function automatic logic signed [32:0] sat_q32(input logic signed [CX_W-1:0] v);
        logic signed [CX_W-1:0] lim;
        lim = $signed({{(CX_W-32){1'b0}}, 32'hFFFF_FFFF});
        if (v > lim)
            return 33'sh0_FFFF_FFFF;
        else if (v < -lim)
            return -33'sh0_FFFF_FFFF;
        else
            return v[32:0];
    endfunction

    function automatic logic [31:0] mag32(input logic signed [32:0] v);
        logic signed [32:0] t;
        t = v[32] ? -v : v;
        return t[31:0];
    endfunction

    function automatic logic [OW-1:0] sat_add(input logic [OW-1:0] od,
                                              input logic [STEP_W-1:0] d);
        logic [SW-1:0] s;
        s = SW'(od) + SW'(d);
        if (s > SW'({OW{1'b1}}))
            return '1;
        else
            return s[OW-1:0];
    endfunction

    function automatic logic [ODO_OUT_W-1:0] clamp_out(input logic [OW-1:0] od);
        logic [CW-1:0] e;
        e = CW'(od);
        if (e > CW'({ODO_OUT_W{1'b1}}))
            return '1;
        else
            return e[ODO_OUT_W-1:0];
    endfunction

    gho_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .quotient (div_q),
        .done     (div_done)
    );

    gho_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cx_cmd),
        .x0    (cx_x0),
        .y0    (cx_y0),
        .z0    (cx_z0),
        .x     (cx_x),
        .y     (cx_y),
        .z     (cx_z),
        .done  (cx_done)
    );

    gho_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .p     (mul_p),
        .done  (mul_done)
    );

    gho_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .v     (sqrt_v),
        .root  (sqrt_r),
        .done  (sqrt_done)
    );

    // angle source: half lat delta, half lon delta, old lat, new lat
    always_comb
    begin
        case (idx_reg)
            2'd0:    vsrc = {lat_reg[31], lat_reg} - {prev_lat_reg[31], prev_lat_reg};
            2'd1:    vsrc = {lon_reg[31], lon_reg} - {prev_lon_reg[31], prev_lon_reg};
            2'd2:    vsrc = {prev_lat_reg[31], prev_lat_reg};
            default: vsrc = {lat_reg[31], lat_reg};
        endcase
        vabs = vsrc[32] ? -vsrc : vsrc;
        if (!idx_reg[1])
            dividend = DIV_N_W'({vabs[31:0], 28'd0}) + DIV_N_W'(DIV_HALF);
        else
            dividend = DIV_N_W'({vabs[31:0], 29'd0}) + DIV_N_W'(DIV_HALF);
    end

    // fold the angle into the right half plane before rotating
    always_comb
    begin
        ang  = neg_reg ? 32'd0 - div_q : div_q;
        flip = ang[31] ^ ang[30];
        ang2 = flip ? ang + 32'h8000_0000 : ang;
        xs   = flip_reg ? -cx_x : cx_x;
        ys   = flip_reg ? -cx_y : cx_y;
    end

    always_comb
    begin
        prod_rnd  = mul_p + 64'h8000_0000;
        mq        = prod_rnd[63:32];
        scale_rnd = mul_p + 64'h0080_0000;
        hsum = $signed({2'b00, m1_reg}) +
               (s2_reg ? -$signed({2'b00, mq}) : $signed({2'b00, mq}));
        if (hsum < 0)
            hav_c = '0;
        else if (hsum > 34'sh1_0000_0000)
            hav_c = 33'h1_0000_0000;
        else
            hav_c = hsum[32:0];
        if (cx_z < 0)
            zc = '0;
        else if (cx_z > $signed(CZ_W'(32'h4000_0000)))
            zc = 31'h4000_0000;
        else
            zc = cx_z[30:0];
        counted = spd_valid_reg && (speed_reg > thr_reg) &&
                  (step_reg < STEP_W'(maxstep_reg));
    end

    always_comb
    begin
        if (state_reg == ST_VEC)
        begin
            mul_a = {zc, 1'b0};
            mul_b = MM_PER_TURN;
        end
        else
        begin
            case (idx_reg)
                2'd0:
                begin
                    mul_a = mag32(sl_reg);
                    mul_b = mag32(sl_reg);
                end
                2'd1:
                begin
                    mul_a = mag32(sn_reg);
                    mul_b = mag32(sn_reg);
                end
                2'd2:
                begin
                    mul_a = mag32(c1_reg);
                    mul_b = mag32(c2_reg);
                end
                default:
                begin
                    mul_a = m2_reg;
                    mul_b = m3_reg;
                end
            endcase
        end
        sqrt_v = (idx_reg == 2'd0) ? hav_reg : 33'h1_0000_0000 - hav_reg;
        if (state_reg == ST_ROOT)
        begin
            cx_x0 = $signed({{(CX_W-32){1'b0}}, sqrt_r});
            cx_y0 = $signed({{(CX_W-32){1'b0}}, ra_reg});
            cx_z0 = '0;
        end
        else
        begin
            cx_x0 = CORDIC_X0;
            cx_y0 = '0;
            cx_z0 = $signed({{(CZ_W-32){ang2[31]}}, ang2});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        item.ready       = 1'b0;
        div_start        = 1'b0;
        cx_cmd.start     = 1'b0;
        cx_cmd.vectoring = 1'b0;
        mul_start        = 1'b0;
        sqrt_start       = 1'b0;
        load_out         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item.ready = 1'b1;
                if (item.valid)
                begin
                    if (item.opcode == OP_FIX && item.location_valid && have_prev_reg)
                        state_next = ST_PREP;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_PREP:
            begin
                div_start  = 1'b1;
                state_next = ST_CONV;
            end
            ST_CONV:
            begin
                if (div_done)
                begin
                    cx_cmd.start = 1'b1;
                    state_next   = ST_ROT;
                end
            end
            ST_ROT:
            begin
                if (cx_done)
                    state_next = (idx_reg == 2'd3) ? ST_MLAUNCH : ST_PREP;
            end
            ST_MLAUNCH:
            begin
                mul_start  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_done)
                    state_next = (idx_reg == 2'd3) ? ST_RLAUNCH : ST_MLAUNCH;
            end
            ST_RLAUNCH:
            begin
                sqrt_start = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (sqrt_done)
                begin
                    if (idx_reg == 2'd0)
                        state_next = ST_RLAUNCH;
                    else
                    begin
                        cx_cmd.start     = 1'b1;
                        cx_cmd.vectoring = 1'b1;
                        state_next       = ST_VEC;
                    end
                end
            end
            ST_VEC:
            begin
                if (cx_done)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (mul_done)
                    state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= 18'd300;
            maxstep_reg   <= 20'd500000;
            prev_lat_reg  <= '0;
            prev_lon_reg  <= '0;
            have_prev_reg <= 1'b0;
            daily_reg     <= '0;
            total_reg     <= '0;
            service_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SPEED_THRESHOLD: thr_reg     <= cfg_data[17:0];
                    CFG_MAX_STEP:        maxstep_reg <= cfg_data;
                    default:             thr_reg     <= thr_reg;
                endcase
            end
            if (accept)
            begin
                case (item.opcode)
                    OP_CLR_DAILY:   daily_reg   <= '0;
                    OP_CLR_SERVICE: service_reg <= '0;
                    OP_FIX:
                    begin
                        // first fix: store the position, no step
                        if (item.location_valid && !have_prev_reg)
                        begin
                            prev_lat_reg  <= {item.latitude[30], item.latitude};
                            prev_lon_reg  <= item.longitude;
                            have_prev_reg <= 1'b1;
                        end
                    end
                    default: have_prev_reg <= have_prev_reg;
                endcase
            end
            if (state_reg == ST_ACCUM)
            begin
                if (counted)
                begin
                    daily_reg   <= sat_add(daily_reg, step_reg);
                    total_reg   <= sat_add(total_reg, step_reg);
                    service_reg <= sat_add(service_reg, step_reg);
                end
                prev_lat_reg <= lat_reg;
                prev_lon_reg <= lon_reg;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    lat_reg       <= {item.latitude[30], item.latitude};
                    lon_reg       <= item.longitude;
                    spd_valid_reg <= item.speed_valid;
                    speed_reg     <= item.speed;
                    idx_reg       <= 2'd0;
                    step_reg      <= '0;
                    counted_reg   <= 1'b0;
                end
            end
            ST_PREP:
            begin
                neg_reg <= vsrc[32];
            end
            ST_CONV:
            begin
                if (div_done)
                    flip_reg <= flip;
            end
            ST_ROT:
            begin
                if (cx_done)
                begin
                    case (idx_reg)
                        2'd0:    sl_reg <= sat_q32(ys);
                        2'd1:    sn_reg <= sat_q32(ys);
                        2'd2:    c1_reg <= sat_q32(xs);
                        default: c2_reg <= sat_q32(xs);
                    endcase
                    idx_reg <= idx_reg + 2'd1;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    case (idx_reg)
                        2'd0: m1_reg <= mq;
                        2'd1: m3_reg <= mq;
                        2'd2:
                        begin
                            m2_reg <= mq;
                            s2_reg <= c1_reg[32] ^ c2_reg[32];
                        end
                        default: hav_reg <= hav_c;
                    endcase
                    idx_reg <= idx_reg + 2'd1;
                end
            end
            ST_ROOT:
            begin
                if (sqrt_done)
                begin
                    ra_reg  <= sqrt_r;
                    idx_reg <= idx_reg + 2'd1;
                end
            end
            ST_SCALE:
            begin
                if (mul_done)
                    step_reg <= scale_rnd[58:24];
            end
            ST_ACCUM:
            begin
                counted_reg <= counted;
            end
            default:
            begin
                counted_reg <= counted_reg;
            end
        endcase
        if (load_out)
        begin
            out_daily_reg   <= clamp_out(daily_reg);
            out_total_reg   <= clamp_out(total_reg);
            out_service_reg <= clamp_out(service_reg);
            out_step_reg    <= step_reg;
            out_counted_reg <= counted_reg;
            out_known_reg   <= have_prev_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.daily_mm       = out_daily_reg;
    assign result.total_mm       = out_total_reg;
    assign result.service_mm     = out_service_reg;
    assign result.step_mm        = out_step_reg;
    assign result.step_counted   = out_counted_reg;
    assign result.position_known = out_known_reg;
endmodule

[bench/tb_gps_haversine_odometer_top.sv]
module tb_gps_haversine_odometer_top;
    import gho_pkg::*;

    localparam int ITERS      = 32;
    localparam int ODO_W      = 48;
    localparam int WDOG_LIMIT = 20000;
    localparam int N_RANDOM   = 800;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam longint unsigned ODO_MAX = (64'd1 << ODO_W) - 1;
    localparam longint unsigned OUT_MAX = (64'd1 << ODO_OUT_W) - 1;
    localparam longint unsigned Q32_MAX = 64'hFFFF_FFFF;

    typedef struct {
        logic [1:0]         op;
        logic signed [30:0] lat;
        logic signed [31:0] lon;
        logic               loc_ok;
        logic               spd_ok;
        logic [17:0]        spd;
    } fix_t;

    typedef struct {
        logic [46:0] daily;
        logic [46:0] total;
        logic [46:0] service;
        logic [34:0] step;
        logic        counted;
        logic        known;
    } odo_reading_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [19:0] cfg_data;

    gho_in_if  in_ch ();
    gho_out_if out_ch ();

    gps_haversine_odometer_top #(
        .CORDIC_ITERATIONS (ITERS),
        .ODOMETER_WIDTH    (ODO_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (in_ch),
        .result    (out_ch)
    );

    // shadow of the block state and registers
    logic [17:0]     m_threshold;
    logic [19:0]     m_max_step;
    longint          m_prev_lat;
    longint          m_prev_lon;
    logic            m_have_prev;
    longint unsigned m_daily;
    longint unsigned m_total;
    longint unsigned m_service;

    odo_reading_t    pending_readings[$];
    int              mismatches;
    int              idle_cycles;
    bit              no_idle;
    int              rx_hold;
    longint          walk_lat;
    longint          walk_lon;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [31:0] deg_to_angle(input longint v, input int sh);
        longint unsigned m;
        longint unsigned q;
        m = (v < 0) ? -v : v;
        q = ((m << sh) + 64'd225000000) / 64'd450000000;
        if (v < 0)
            q = -q;
        return q[31:0];
    endfunction

    function automatic longint clamp_q32(input longint v);
        if (v > longint'(Q32_MAX))
            return longint'(Q32_MAX);
        if (v < -longint'(Q32_MAX))
            return -longint'(Q32_MAX);
        return v;
    endfunction

    function automatic void cordic_sincos(input logic [31:0] ang, output longint s,
                                          output longint c);
        logic [31:0] t;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        t = ang + 32'h4000_0000;
        flip = t[31];
        if (flip)
            ang = ang + 32'h8000_0000;
        z = $signed(ang);
        x = 64'sd2608131496;
        y = 0;
        for (int i = 0; i < ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[i]);
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[i]);
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        s = clamp_q32(y);
        c = clamp_q32(x);
    endfunction

    function automatic longint q32_mul(input longint a, input longint b);
        logic            neg;
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned p;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        p = (ua * ub + 64'h8000_0000) >> 32;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned q32_sqrt(input longint unsigned v);
        longint unsigned x;
        longint unsigned r;
        longint unsigned b;
        x = (v >= 64'h1_0000_0000) ? 64'hFFFF_FFFF_FFFF_FFFF : (v << 32);
        r = 0;
        b = 64'd1 << 62;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint cordic_atan2(input longint y, input longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[i]);
            end
            else
            begin
                x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[i]);
            end
        end
        if (z < 0)
            z = 0;
        if (z > (64'sd1 << 30))
            z = 64'sd1 << 30;
        return z;
    endfunction

    function automatic longint unsigned great_circle_mm(input longint lat1, input longint lon1,
                                                        input longint lat2, input longint lon2);
        longint          sl, cl, sn, cn, s1, c1, s2, c2, hav;
        longint unsigned ra, rb, cb;
        cordic_sincos(deg_to_angle(lat2 - lat1, 28), sl, cl);
        cordic_sincos(deg_to_angle(lon2 - lon1, 28), sn, cn);
        cordic_sincos(deg_to_angle(lat1, 29), s1, c1);
        cordic_sincos(deg_to_angle(lat2, 29), s2, c2);
        hav = q32_mul(sl, sl) + q32_mul(q32_mul(c1, c2), q32_mul(sn, sn));
        if (hav < 0)
            hav = 0;
        if (hav > (64'sd1 << 32))
            hav = 64'sd1 << 32;
        ra = q32_sqrt(hav);
        rb = q32_sqrt((64'd1 << 32) - hav);
        cb = 2 * longint'(cordic_atan2(ra, rb));
        return (cb * longint'(MM_PER_TURN) + (64'd1 << 23)) >> 24;
    endfunction

    function automatic longint unsigned odo_add(input longint unsigned od,
                                                input longint unsigned d);
        if (od >= ODO_MAX || ODO_MAX - od < d)
            return ODO_MAX;
        return od + d;
    endfunction

    function automatic logic [46:0] odo_view(input longint unsigned v);
        return (v > OUT_MAX) ? OUT_MAX[46:0] : v[46:0];
    endfunction

    function automatic odo_reading_t advance_odometer(input fix_t f);
        odo_reading_t    r;
        longint unsigned step;
        longint          lat;
        longint          lon;
        logic            moving;
        step = 0;
        r.counted = 1'b0;
        if (f.op == OP_CLR_DAILY)
            m_daily = 0;
        else if (f.op == OP_CLR_SERVICE)
            m_service = 0;
        else if (f.op == OP_FIX && f.loc_ok)
        begin
            lat = f.lat;
            lon = f.lon;
            moving = f.spd_ok && (f.spd > m_threshold);
            if (m_have_prev)
            begin
                step = great_circle_mm(m_prev_lat, m_prev_lon, lat, lon);
                if (moving && step < m_max_step)
                begin
                    m_daily   = odo_add(m_daily, step);
                    m_total   = odo_add(m_total, step);
                    m_service = odo_add(m_service, step);
                    r.counted = 1'b1;
                end
            end
            m_prev_lat  = lat;
            m_prev_lon  = lon;
            m_have_prev = 1'b1;
        end
        r.daily   = odo_view(m_daily);
        r.total   = odo_view(m_total);
        r.service = odo_view(m_service);
        r.step    = step[34:0];
        r.known   = m_have_prev;
        return r;
    endfunction

    function automatic fix_t mk(input logic [1:0] op, input longint lat, input longint lon,
                                input logic loc_ok, input logic spd_ok, input longint spd);
        fix_t f;
        f.op     = op;
        f.lat    = lat[30:0];
        f.lon    = lon[31:0];
        f.loc_ok = loc_ok;
        f.spd_ok = spd_ok;
        f.spd    = spd[17:0];
        return f;
    endfunction

    task automatic send_item(input fix_t f);
        int gap;
        gap = no_idle ? 0 : (($urandom_range(99) < 20) ? $urandom_range(1, 6) : 0);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.opcode         <= f.op;
        in_ch.latitude       <= f.lat;
        in_ch.longitude      <= f.lon;
        in_ch.location_valid <= f.loc_ok;
        in_ch.speed_valid    <= f.spd_ok;
        in_ch.speed          <= f.spd;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_readings.push_back(advance_odometer(f));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [19:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_SPEED_THRESHOLD)
            m_threshold = val[17:0];
        else
            m_max_step = val;
    endtask

    task automatic test_directed();
        send_item(mk(OP_UNUSED, 5, 5, 1, 1, 1000));
        send_item(mk(OP_FIX, 1000, 1000, 0, 1, 1000));
        send_item(mk(OP_FIX, 0, 0, 1, 1, 1000));
        send_item(mk(OP_FIX, 10000, 10000, 1, 1, 1000));
        send_item(mk(OP_FIX, 20000, 15000, 1, 0, 1000));
        send_item(mk(OP_FIX, 25000, 15000, 1, 1, 300));
        send_item(mk(OP_FIX, 30000, 16000, 1, 1, 301));
        send_item(mk(OP_FIX, 30000, 16000, 1, 1, 18'h3FFFF));
        send_item(mk(OP_FIX, 900000000, 1800000000, 1, 1, 1000));
        send_item(mk(OP_FIX, -900000000, -1800000000, 1, 1, 1000));
        send_item(mk(OP_FIX, 900000000, 0, 1, 1, 1000));
        // out-of-range coordinates wrap
        send_item(mk(OP_FIX, (1 << 30) - 1, 32'h7FFF_FFFF, 1, 1, 1000));
        send_item(mk(OP_FIX, -(1 << 30), -(64'sd1 << 31), 1, 1, 1000));
        send_item(mk(OP_FIX, -(1 << 30) + 40000, -(64'sd1 << 31), 1, 1, 2000));
        send_item(mk(OP_CLR_DAILY, 0, 0, 0, 0, 0));
        send_item(mk(OP_FIX, -(1 << 30) + 41000, -(64'sd1 << 31) + 500, 1, 1, 2000));
        send_item(mk(OP_CLR_SERVICE, 0, 0, 0, 0, 0));
        send_item(mk(OP_UNUSED, 0, 0, 1, 1, 0));
        send_item(mk(OP_FIX, 0, 0, 1, 1, 0));
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_SPEED_THRESHOLD, 20'd0);
        write_reg(CFG_MAX_STEP, 20'd1000000);
        send_item(mk(OP_FIX, 3000, 3000, 1, 1, 0));
        send_item(mk(OP_FIX, 9000, -2000, 1, 1, 1));
        send_item(mk(OP_FIX, 70000, -2000, 1, 1, 1));
        write_reg(CFG_SPEED_THRESHOLD, 20'd200000);
        write_reg(CFG_MAX_STEP, 20'd0);
        send_item(mk(OP_FIX, 71000, -2000, 1, 1, 200000));
        send_item(mk(OP_FIX, 72000, -2000, 1, 1, 200001));
        write_reg(CFG_MAX_STEP, 20'd1000000);
        send_item(mk(OP_FIX, 73000, -2500, 1, 1, 200001));
        write_reg(CFG_SPEED_THRESHOLD, 20'd300);
        write_reg(CFG_MAX_STEP, 20'd500000);
    endtask

    task automatic random_fix_or_noise(output fix_t f);
        int     pick;
        longint d;
        pick = $urandom_range(99);
        if (pick < 8)
            f = mk(2'($urandom_range(1, 3)), $urandom, $urandom, 1'($urandom),
                   1'($urandom), $urandom);
        else if (pick < 18)
            f = mk(OP_FIX, $urandom, $urandom, 0, 1'($urandom), $urandom);
        else if (pick < 24)
        begin
            walk_lat = longint'($signed(31'($urandom)));
            walk_lon = longint'($signed(32'($urandom)));
            f = mk(OP_FIX, walk_lat, walk_lon, 1, 1'($urandom), $urandom);
        end
        else
        begin
            d = ($urandom_range(9) == 0) ? 200000 : 30000;
            walk_lat = walk_lat + $urandom_range(2 * d) - d;
            walk_lon = walk_lon + $urandom_range(2 * d) - d;
            walk_lat = longint'($signed(walk_lat[30:0]));
            walk_lon = longint'($signed(walk_lon[31:0]));
            f = mk(OP_FIX, walk_lat, walk_lon, 1, $urandom_range(9) != 0,
                   ($urandom_range(9) == 0) ? $urandom : $urandom_range(1200));
        end
    endtask

    task automatic test_random();
        fix_t f;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            no_idle = (n >= 300 && n < 400);
            if (n % 200 == 199)
            begin
                write_reg(CFG_SPEED_THRESHOLD, 20'($urandom_range(600)));
                write_reg(CFG_MAX_STEP, 20'($urandom_range(200000, 1000000)));
            end
            random_fix_or_noise(f);
            send_item(f);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        fix_t f;
        // stall the receiver so the block fills and holds off its input
        rx_hold = 3000;
        for (int n = 0; n < 6; n++)
        begin
            random_fix_or_noise(f);
            send_item(f);
        end
        drain();
    endtask

    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= no_idle || ($urandom_range(99) >= 20);
    end

    always @(posedge clk)
    begin
        odo_reading_t e;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT)
        begin
            $display("** gps_haversine_odometer_top: FAILED **");
            $finish;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_readings.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result beat: daily %0d step %0d",
                             out_ch.daily_mm, out_ch.step_mm);
                mismatches++;
            end
            else
            begin
                e = pending_readings.pop_front();
                if (out_ch.daily_mm !== e.daily || out_ch.total_mm !== e.total ||
                    out_ch.service_mm !== e.service || out_ch.step_mm !== e.step ||
                    out_ch.step_counted !== e.counted || out_ch.position_known !== e.known)
                begin
                    if (mismatches < 10)
                    begin
                        $display("mismatch: exp d=%0d t=%0d s=%0d st=%0d c=%b k=%b",
                                 e.daily, e.total, e.service, e.step, e.counted, e.known);
                        $display("          got d=%0d t=%0d s=%0d st=%0d c=%b k=%b",
                                 out_ch.daily_mm, out_ch.total_mm, out_ch.service_mm,
                                 out_ch.step_mm, out_ch.step_counted,
                                 out_ch.position_known);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_SPEED_THRESHOLD;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.opcode         = OP_FIX;
        in_ch.latitude       = '0;
        in_ch.longitude      = '0;
        in_ch.location_valid = 1'b0;
        in_ch.speed_valid    = 1'b0;
        in_ch.speed          = '0;
        out_ch.ready         = 1'b0;
        mismatches           = 0;
        idle_cycles          = 0;
        no_idle              = 1'b0;
        rx_hold              = 0;
        walk_lat             = 0;
        walk_lon             = 0;
        m_threshold          = 18'd300;
        m_max_step           = 20'd500000;
        m_prev_lat           = 0;
        m_prev_lon           = 0;
        m_have_prev          = 1'b0;
        m_daily              = 0;
        m_total              = 0;
        m_service            = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random();
        test_backpressure();
        drain();
        repeat (50) @(posedge clk);

        if (mismatches == 0 && pending_readings.size() == 0)
            $display("** gps_haversine_odometer_top: PASSED **");
        else
            $display("** gps_haversine_odometer_top: FAILED **");
        $finish;
    end

endmodule
